FILE: sv/eett_pkg.sv
// Shared types, constants and codes for the earliest event timer table.
package eett_pkg;

  // Number of event sources held in the table.
  localparam int EVENT_COUNT = 8;
  localparam int IDX_W       = $clog2(EVENT_COUNT);

  // Fixed field widths of the transfer payloads.
  localparam int OP_W   = 2;
  localparam int EV_W   = 3;
  localparam int TIME_W = 32;

  // Command queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Operation codes on the input channel.
  localparam logic [OP_W-1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [OP_W-1:0] OP_RESCHEDULE = 2'd1;
  localparam logic [OP_W-1:0] OP_PROCESS    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [EV_W-1:0]   event_id;
    logic [TIME_W-1:0] at_time;
    logic [TIME_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [EV_W-1:0]   fired_event;
    logic              active;
    logic [EV_W-1:0]   earliest_event;
    logic [TIME_W-1:0] earliest_time;
  } out_item_t;

  // Classified command; unusable requests collapse to CMD_NOP.
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SCHED,
    CMD_RESCHED,
    CMD_PROC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] at;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // Front to queue handshake.
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  // Queue to back status.
  typedef struct packed {
    logic avail;
  } q_rd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_SCAN,
    B_OFFER,
    B_DONE
  } back_state_t;

endpackage

FILE: sv/earliest_event_timer_table_top.sv
// Top level of the earliest event timer table: front end, command queue, back end.
//
//   Port group  Dir  Payload            Transfer when
//   in_*        in   eett_pkg::in_item_t  in_valid && in_ready
//   out_*       out  eett_pkg::out_item_t out_valid && out_ready
//
// Sequence: each item is fetched, executed and its result registered in the
// back end; a due process or a reschedule of the earliest source adds a
// rescan of all EVENT_COUNT entries over the single table read port, and a
// reschedule then offers its new deadline. The back end takes a new item
// from the queue only once the last result has been registered.
// Reset: rst_n is synchronous, active low; it empties the table (all valid
// bits), the queue and the result register.
// Stalls: a held result blocks only the back end; the queue keeps taking
// input transfers until its QUEUE_DEPTH entries are full.
module earliest_event_timer_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  eett_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output eett_pkg::out_item_t out_data
);
  import eett_pkg::*;

  // front -> queue
  q_wr_t wr_ctl;
  cmd_t  wr_cmd;

  // queue -> back
  q_rd_t rd_ctl;
  cmd_t  rd_cmd;
  logic  back_pop;

  // Classification only; no state in the front end.
  eett_front u_front (
    .in_data  (in_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (wr_ctl.full),
    .q_push   (wr_ctl.push),
    .q_cmd    (wr_cmd)
  );

  eett_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_push (wr_ctl.push),
    .wr_full (wr_ctl.full),
    .wr_cmd  (wr_cmd),
    .rd_ctl  (rd_ctl),
    .rd_pop  (back_pop),
    .rd_cmd  (rd_cmd)
  );

  // Table, earliest tracking and result register live in the back end.
  eett_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (rd_ctl),
    .q_pop     (back_pop),
    .q_cmd     (rd_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/eett_front.sv
// Front end: takes input transfers and classifies them into commands.
module eett_front (
  input  eett_pkg::in_item_t in_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               q_full,
  output logic               q_push,
  output eett_pkg::cmd_t     q_cmd
);
  import eett_pkg::*;

  logic usable;

  // Zero deadline and out-of-range sources turn a schedule or reschedule into a no-op.
  assign usable = (in_data.at_time != '0) &&
                  (32'(in_data.event_id) < 32'(EVENT_COUNT));

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.idx = IDX_W'(in_data.event_id);
    q_cmd.at  = in_data.at_time;
    q_cmd.now = in_data.now;
    case (in_data.operation)
      OP_SCHEDULE:   q_cmd.kind = usable ? CMD_SCHED : CMD_NOP;
      OP_RESCHEDULE: q_cmd.kind = usable ? CMD_RESCHED : CMD_NOP;
      OP_PROCESS:    q_cmd.kind = CMD_PROC;
      default:       q_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

FILE: sv/eett_queue.sv
// Short command queue decoupling the front end from the back end.
module eett_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_push,
  output logic           wr_full,
  input  eett_pkg::cmd_t wr_cmd,
  output eett_pkg::q_rd_t rd_ctl,
  input  logic           rd_pop,
  output eett_pkg::cmd_t rd_cmd
);
  import eett_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign wr_full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_ctl.avail = (count_r != '0);
  assign rd_cmd       = mem_r[rd_ptr_r];

  assign do_push = wr_push && !wr_full;
  assign do_pop  = rd_pop && rd_ctl.avail;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

FILE: sv/eett_back.sv
// Back end: deadline table, earliest tracking, rescan sequencer, result register.
module eett_back (
  input  logic                clk,
  input  logic                rst_n,
  input  eett_pkg::q_rd_t     q_ctl,
  output logic                q_pop,
  input  eett_pkg::cmd_t      q_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output eett_pkg::out_item_t out_data
);
  import eett_pkg::*;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;

  // Deadline table: valid bit per entry, payload without reset.
  logic [TIME_W-1:0] table_r [EVENT_COUNT];
  logic [EVENT_COUNT-1:0] valid_r, valid_nxt;
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [TIME_W-1:0] tbl_wdata;

  logic              any_r, any_nxt;
  logic [IDX_W-1:0]  soon_idx_r, soon_idx_nxt;
  logic [TIME_W-1:0] soon_dl_r, soon_dl_nxt;

  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_r, best_nxt;

  logic              fired_r, fired_nxt;
  logic [IDX_W-1:0]  fired_idx_r, fired_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [IDX_W-1:0]  rd_addr;
  logic              rd_valid;
  logic [TIME_W-1:0] rd_dl;
  logic              offer_take;
  logic              scan_hit;
  logic              scan_last;

  // Single table read port, shared by command execution and the rescan.
  assign rd_addr  = (state_r == B_SCAN) ? scan_idx_r : cmd_r.idx;
  assign rd_valid = valid_r[rd_addr];
  assign rd_dl    = table_r[rd_addr];

  assign offer_take = !any_r || (cmd_r.at < soon_dl_r);
  assign scan_hit   = rd_valid && (!found_r || (rd_dl < best_r));
  assign scan_last  = (scan_idx_r == IDX_W'(EVENT_COUNT - 1));

  assign q_pop     = (state_r == B_IDLE) && q_ctl.avail;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    valid_nxt     = valid_r;
    tbl_we        = 1'b0;
    tbl_waddr     = cmd_r.idx;
    tbl_wdata     = cmd_r.at;
    any_nxt       = any_r;
    soon_idx_nxt  = soon_idx_r;
    soon_dl_nxt   = soon_dl_r;
    scan_idx_nxt  = scan_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    fired_nxt     = fired_r;
    fired_idx_nxt = fired_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    case (state_r)
      B_IDLE: begin
        if (q_ctl.avail) begin
          cmd_nxt       = q_cmd;
          fired_nxt     = 1'b0;
          fired_idx_nxt = '0;
          state_nxt     = B_EXEC;
        end
      end

      B_EXEC: begin
        state_nxt = B_DONE;
        case (cmd_r.kind)
          CMD_SCHED: begin
            // keep the earlier of old and new
            if (!rd_valid || (cmd_r.at < rd_dl)) begin
              tbl_we              = 1'b1;
              valid_nxt[cmd_r.idx] = 1'b1;
            end
            if (offer_take) begin
              any_nxt      = 1'b1;
              soon_idx_nxt = cmd_r.idx;
              soon_dl_nxt  = cmd_r.at;
            end
          end
          CMD_RESCHED: begin
            tbl_we               = 1'b1;
            valid_nxt[cmd_r.idx] = 1'b1;
            if (any_r && (soon_idx_r == cmd_r.idx)) begin
              scan_idx_nxt = '0;
              found_nxt    = 1'b0;
              best_idx_nxt = '0;
              best_nxt     = '0;
              state_nxt    = B_SCAN;
            end else if (offer_take) begin
              any_nxt      = 1'b1;
              soon_idx_nxt = cmd_r.idx;
              soon_dl_nxt  = cmd_r.at;
            end
          end
          CMD_PROC: begin
            if (any_r && (soon_dl_r <= cmd_r.now)) begin
              valid_nxt[soon_idx_r] = 1'b0;
              fired_nxt     = 1'b1;
              fired_idx_nxt = soon_idx_r;
              scan_idx_nxt  = '0;
              found_nxt     = 1'b0;
              best_idx_nxt  = '0;
              best_nxt      = '0;
              state_nxt     = B_SCAN;
            end
          end
          default: begin
            state_nxt = B_DONE;
          end
        endcase
      end

      B_SCAN: begin
        // lowest index wins ties: strict less-than
        if (scan_hit) begin
          found_nxt    = 1'b1;
          best_idx_nxt = scan_idx_r;
          best_nxt     = rd_dl;
        end
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_last) begin
          any_nxt      = found_nxt;
          soon_idx_nxt = best_idx_nxt;
          soon_dl_nxt  = best_nxt;
          state_nxt    = (cmd_r.kind == CMD_RESCHED) ? B_OFFER : B_DONE;
        end
      end

      B_OFFER: begin
        if (offer_take) begin
          any_nxt      = 1'b1;
          soon_idx_nxt = cmd_r.idx;
          soon_dl_nxt  = cmd_r.at;
        end
        state_nxt = B_DONE;
      end

      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.fired          = fired_r;
          out_nxt.fired_event    = EV_W'(fired_idx_r);
          out_nxt.active         = any_r;
          out_nxt.earliest_event = any_r ? EV_W'(soon_idx_r) : '0;
          out_nxt.earliest_time  = any_r ? soon_dl_r : '0;
          state_nxt              = B_IDLE;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      any_r       <= 1'b0;
      soon_idx_r  <= '0;
      soon_dl_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      any_r       <= any_nxt;
      soon_idx_r  <= soon_idx_nxt;
      soon_dl_r   <= soon_dl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    scan_idx_r  <= scan_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_r      <= best_nxt;
    fired_r     <= fired_nxt;
    fired_idx_r <= fired_idx_nxt;
    out_r       <= out_nxt;
    if (tbl_we) begin
      table_r[tbl_waddr] <= tbl_wdata;
    end
  end

  // Between commands the tracked earliest source is a live table entry.
  a_earliest_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && any_r) |-> valid_r[soon_idx_r])
    else $error("earliest source not pending in table");

  // Between commands an idle tracker means an empty table.
  a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && !any_r) |-> (valid_r == '0))
    else $error("table holds entries while nothing is pending");

  // The rescan walks the table one entry per cycle.
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN && !scan_last) |=>
      (state_r == B_SCAN && scan_idx_r == $past(scan_idx_r) + IDX_W'(1)))
    else $error("rescan skipped or left early");

  // A fired event is no longer pending once the command completes.
  a_fired_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE && fired_r) |-> !valid_r[fired_idx_r])
    else $error("fired event still pending");

endmodule

FILE: tb/tb_earliest_event_timer_table_top.sv
// Self-checking testbench for the earliest event timer table: directed and random traffic.
module tb_earliest_event_timer_table_top;
  import eett_pkg::*;

  // Operation code with no effect; the block must report state only.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1630;
  localparam int DRAIN_CYCLES = 40;      // margin for the slowest back end item plus queue slots
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 250;     // long receiver hold-off, to back up the queue
  localparam int MAX_REPORTS  = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  earliest_event_timer_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Timer table predictor: own copy of deadlines and of the earliest tracker.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] ev_deadline [EVENT_COUNT];
  logic [EV_W-1:0]   soon_idx   = '0;
  logic [TIME_W-1:0] soon_at    = '0;
  logic              soon_valid = 1'b0;

  initial begin
    for (int i = 0; i < EVENT_COUNT; i++) ev_deadline[i] = '0;
  end

  // Lowest index among the smallest nonzero deadlines; empty table clears all.
  function automatic void rescan_deadlines();
    logic              found;
    logic [EV_W-1:0]   best_idx;
    logic [TIME_W-1:0] best_at;
    found    = 1'b0;
    best_idx = '0;
    best_at  = '0;
    for (int i = 0; i < EVENT_COUNT; i++) begin
      if (ev_deadline[i] != '0 && (!found || ev_deadline[i] < best_at)) begin
        found    = 1'b1;
        best_idx = EV_W'(i);
        best_at  = ev_deadline[i];
      end
    end
    soon_valid = found;
    soon_idx   = best_idx;
    soon_at    = best_at;
  endfunction

  // A tie with the current earliest does not move it.
  function automatic void offer_soonest(logic [TIME_W-1:0] at, logic [EV_W-1:0] ev);
    if (!soon_valid || at < soon_at) begin
      soon_at    = at;
      soon_idx   = ev;
      soon_valid = 1'b1;
    end
  endfunction

  function automatic out_item_t apply_timer_op(in_item_t it);
    out_item_t res;
    logic      usable;
    res    = '0;
    usable = (it.at_time != '0) && (int'(it.event_id) < EVENT_COUNT);
    case (it.operation)
      OP_SCHEDULE: begin
        if (usable) begin
          if (ev_deadline[it.event_id] == '0 || it.at_time < ev_deadline[it.event_id])
            ev_deadline[it.event_id] = it.at_time;
          offer_soonest(it.at_time, it.event_id);
        end
      end
      OP_RESCHEDULE: begin
        if (usable) begin
          ev_deadline[it.event_id] = it.at_time;
          if (soon_valid && soon_idx == it.event_id) rescan_deadlines();
          offer_soonest(it.at_time, it.event_id);
        end
      end
      OP_PROCESS: begin
        // only fires while something is pending
        if (soon_valid && soon_at <= it.now) begin
          res.fired       = 1'b1;
          res.fired_event = soon_idx;
          ev_deadline[soon_idx] = '0;
          rescan_deadlines();
        end
      end
      default: ;
    endcase
    res.active         = soon_valid;
    res.earliest_event = soon_valid ? soon_idx : '0;
    res.earliest_time  = soon_valid ? soon_at : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Pending items, expected results and bookkeeping.
  // ---------------------------------------------------------------------------
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors        = 0;
  int        results_seen  = 0;
  int        cycle_count   = 0;
  int        in_xfers      = 0;   // input transfers, counted by the monitor
  int        in_xfers_seen = 0;   // last count the sender has acted on

  function automatic void push_item(logic [OP_W-1:0] op, logic [EV_W-1:0] ev,
                                    logic [TIME_W-1:0] at, logic [TIME_W-1:0] now);
    in_item_t it;
    it.operation = op;
    it.event_id  = ev;
    it.at_time   = at;
    it.now       = now;
    pending_items.push_back(it);
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches of none.
  function automatic int draw_idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string field, logic [TIME_W-1:0] want,
                                        logic [TIME_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, field, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: a new item only once the last one transferred; gap counted after it.
  // ---------------------------------------------------------------------------
  int in_gap  = 0;
  int in_calm = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && in_xfers == in_xfers_seen)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        in_gap   = draw_idle_len(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_xfers_seen = in_xfers;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus two long hold-offs while the sender keeps going.
  // ---------------------------------------------------------------------------
  int out_gap    = 0;
  int out_calm   = 0;
  int hold_left  = 0;
  int holds_done = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && holds_done < 2 &&
          results_seen >= (holds_done == 0 ? 300 : 1100)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        out_gap   = draw_idle_len(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each result transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_timer_op(in_data));
        in_xfers++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result transfer: expected none, got %h",
                     $time, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.fired !== want.fired)
            note_mismatch("fired", TIME_W'(want.fired), TIME_W'(out_data.fired));
          if (out_data.fired_event !== want.fired_event)
            note_mismatch("fired_event", TIME_W'(want.fired_event),
                          TIME_W'(out_data.fired_event));
          if (out_data.active !== want.active)
            note_mismatch("active", TIME_W'(want.active), TIME_W'(out_data.active));
          if (out_data.earliest_event !== want.earliest_event)
            note_mismatch("earliest_event", TIME_W'(want.earliest_event),
                          TIME_W'(out_data.earliest_event));
          if (out_data.earliest_time !== want.earliest_time)
            note_mismatch("earliest_time", want.earliest_time, out_data.earliest_time);
        end
      end
    end
  end

  // Watchdog: generous bound over the slowest legal run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [TIME_W-1:0] window_now;
    logic [EV_W-1:0]   ev;
    int                r;
    int                total_items;

    // Directed: ties, keep-earlier, overwrite of the earliest, zero deadline,
    // unused code, empty table, and boundary times.
    push_item(OP_PROCESS,    3'd0, 32'd1,          32'hFFFF_FFFF); // empty, no fire
    push_item(OP_SCHEDULE,   3'd0, 32'd0,          32'd0);         // zero deadline ignored
    push_item(OP_SCHEDULE,   3'd7, 32'hFFFF_FFFF,  32'd0);
    push_item(OP_SCHEDULE,   3'd3, 32'd100,        32'd0);
    push_item(OP_SCHEDULE,   3'd5, 32'd100,        32'd0);         // tie keeps event 3
    push_item(OP_SCHEDULE,   3'd3, 32'd200,        32'd0);         // later one dropped
    push_item(OP_SCHEDULE,   3'd3, 32'd50,         32'd0);
    push_item(OP_RESCHEDULE, 3'd3, 32'd300,        32'd0);         // earliest moved: rescan
    push_item(OP_RESCHEDULE, 3'd1, 32'd1,          32'd0);
    push_item(OP_UNUSED,     3'd6, 32'h5A5A_A5A5,  32'hFFFF_FFFF);
    push_item(OP_PROCESS,    3'd0, 32'd0,          32'd0);         // not yet due
    push_item(OP_PROCESS,    3'd0, 32'd0,          32'd1);         // fires event 1
    push_item(OP_PROCESS,    3'd0, 32'd0,          32'd99);
    push_item(OP_PROCESS,    3'd0, 32'd0,          32'd100);       // fires event 5
    push_item(OP_RESCHEDULE, 3'd2, 32'd300,        32'd0);         // tie, no move
    push_item(OP_RESCHEDULE, 3'd3, 32'd0,          32'd0);         // zero ignored
    push_item(OP_PROCESS,    3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    push_item(OP_PROCESS,    3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    push_item(OP_PROCESS,    3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF); // drains last one
    push_item(OP_PROCESS,    3'd7, 32'hFFFF_FFFF,  32'hFFFF_FFFF); // empty again
    push_item(OP_SCHEDULE,   3'd6, 32'hFFFF_FFFF,  32'd0);
    push_item(OP_SCHEDULE,   3'd4, 32'h8000_0000,  32'd0);
    push_item(OP_RESCHEDULE, 3'd4, 32'h7FFF_FFFF,  32'd0);         // earliest overwritten
    push_item(OP_PROCESS,    3'd0, 32'd0,          32'h7FFF_FFFF);

    // Random: mostly traffic in a moving time window so deadlines come due,
    // the rest full-range noise and broken requests.
    window_now = $urandom_range(0, 1000);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 249) window_now = $urandom;
      ev = EV_W'($urandom_range(0, EVENT_COUNT - 1));
      r  = $urandom_range(0, 99);
      if (r < 30) begin
        push_item(OP_SCHEDULE, ev, window_now + $urandom_range(1, 200), $urandom);
      end else if (r < 50) begin
        push_item(OP_RESCHEDULE, ev, window_now + $urandom_range(1, 200), $urandom);
      end else if (r < 82) begin
        window_now = window_now + $urandom_range(0, 40);
        push_item(OP_PROCESS, ev, $urandom, window_now);
      end else if (r < 85) begin
        push_item(OP_PROCESS, ev, $urandom, 32'hFFFF_FFFF);        // flush the earliest
      end else if (r < 94) begin
        push_item(OP_W'($urandom_range(0, 3)), ev, $urandom, $urandom);
      end else if (r < 97) begin
        push_item(OP_W'($urandom_range(0, 1)), ev, 32'd0, $urandom); // zero deadline
      end else begin
        push_item(OP_UNUSED, ev, $urandom, $urandom);
      end
    end
    total_items = pending_items.size();

    // Synchronous reset, released off the active edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: every result back, then a quiet margin for strays.
    while (results_seen < total_items)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
